>>> rtl/core/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

  // Field and register widths
  localparam int OP_W     = 2;
  localparam int BIDX_W   = 6;
  localparam int ST_W     = 2;
  localparam int OFF_W    = 18;
  localparam int BSIZE_W  = 13;
  localparam int BCOUNT_W = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  // Configuration reset values
  localparam logic [BSIZE_W-1:0]  BSIZE_RST  = BSIZE_W'(64);
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = BCOUNT_W'(64);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [BIDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [BIDX_W-1:0] granted_index;
    logic [OFF_W-1:0]  granted_offset;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Controller: takes one item, then runs it once the link read has landed
// and the result register is free.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fbfl_pkg::dp_stat_t stat,
  output fbfl_pkg::dp_cmd_t  cmd
);
  import fbfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Accept only when no item is in flight
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC) && stat.out_free;

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/fbfl_dp.sv
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: configuration registers, link memory with per-entry valid flags,
// list head, offset multiplier and result register.
// ----------------------------------------------------------------------------
module fbfl_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fbfl_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fbfl_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  fbfl_pkg::dp_cmd_t                  cmd,
  output fbfl_pkg::dp_stat_t                 stat
);
  import fbfl_pkg::*;

  logic [BSIZE_W-1:0]    block_size_r;
  logic [BCOUNT_W-1:0]   block_count_r;
  logic [LINK_W-1:0]     head_r;
  logic [LINK_W-1:0]     head_nxt;
  op_t                   op_r;
  logic [BIDX_W-1:0]     idx_r;
  logic [MAX_BLOCKS-1:0] link_vld_r;
  logic [MAX_BLOCKS-1:0] link_vld_nxt;
  logic [LINK_W-1:0]     link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]     rd_link_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;
  logic [LINK_W-1:0]     eff_count;
  logic                  head_empty;
  logic [LINK_W-1:0]     fetched_link;
  logic [OFF_W-1:0]      offset;
  logic [IDX_W-1:0]      rel_idx;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BSIZE_RST;
      block_count_r <= BCOUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BLOCK_SIZE)  block_size_r  <= cfg_wdata[BSIZE_W-1:0];
      if (cfg_index == CFG_BLOCK_COUNT) block_count_r <= cfg_wdata[BCOUNT_W-1:0];
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.operation;
      idx_r <= in_data.block_index;
    end
  end

  // Count saturated to the pool size
  always_comb begin
    if (LINK_W'(block_count_r) > END_MARK) eff_count = END_MARK;
    else                                   eff_count = LINK_W'(block_count_r);
  end

  assign head_empty = (head_r >= END_MARK);
  assign rel_idx    = idx_r[IDX_W-1:0];

  // An entry never written since reset or rebuild links to its successor
  assign fetched_link = rd_vld_r ? rd_link_r
                                 : LINK_W'(head_r[IDX_W-1:0]) + LINK_W'(1);

  // Byte offset wraps to the output width
  assign offset = OFF_W'(head_r[IDX_W-1:0]) * OFF_W'(block_size_r);

  // Run the operation
  always_comb begin
    head_nxt     = head_r;
    link_vld_nxt = link_vld_r;
    mem_we       = 1'b0;
    mem_waddr    = rel_idx;
    mem_wdata    = head_r;
    out_data_nxt = '{status: ST_OK, granted_index: '0, granted_offset: '0};
    if (cmd.exec) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (head_empty) begin
            out_data_nxt.status = ST_EMPTY;
          end else begin
            head_nxt                    = fetched_link;
            out_data_nxt.granted_index  = BIDX_W'(head_r[IDX_W-1:0]);
            out_data_nxt.granted_offset = offset;
          end
        end
        OP_RELEASE: begin
          if ((LINK_W'(idx_r) < eff_count) && (LINK_W'(idx_r) < END_MARK)) begin
            mem_we              = 1'b1;
            mem_waddr           = rel_idx;
            mem_wdata           = head_r;
            link_vld_nxt[rel_idx] = 1'b1;
            head_nxt            = LINK_W'(rel_idx);
          end else begin
            out_data_nxt.status = ST_RANGE;
          end
        end
        OP_REBUILD: begin
          // Chain entries below the count; the last one takes the end mark
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (LINK_W'(i + 1) < eff_count) link_vld_nxt[i] = 1'b0;
          end
          if (eff_count != '0) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(eff_count - LINK_W'(1));
            mem_wdata = END_MARK;
            link_vld_nxt[IDX_W'(eff_count - LINK_W'(1))] = 1'b1;
            head_nxt  = '0;
          end else begin
            head_nxt  = END_MARK;
          end
        end
        OP_NOP: begin
          head_nxt = head_r;
        end
        default: head_nxt = head_r;
      endcase
    end
  end

  // Link memory: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_link_r <= link_mem[head_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= link_vld_r[head_r[IDX_W-1:0]];
  end

  // List state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      link_vld_r <= '0;
    end else begin
      head_r     <= head_nxt;
      link_vld_r <= link_vld_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_data_r <= out_data_nxt;
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

>>> rtl/core/fixed_block_free_list_allocator.sv
// Sequence: an item is captured in S_IDLE and run in S_EXEC, once the
//   registered read of the link memory at the list head has landed; no new
//   item is taken until it has run, and it runs only once the result is free.
// Rebuild runs the same way: valid flags clear in parallel.
// Reset (synchronous, rst_n low): list head 0, link table reads i+1 through
//   cleared valid flags, no clearing pass; ready as soon as reset is released.
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-sized blocks handed out from a last-in-first-out free list.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbfl_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbfl_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fbfl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/core/fbfl_checker.sv
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input fbfl_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input fbfl_pkg::out_item_t out_data
);
  import fbfl_pkg::*;

  // Stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input payload changed while stalled");

  // Stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item in flight: no transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in consecutive cycles");

  // Failed results carry zero index and offset
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.granted_index == '0) && (out_data.granted_offset == '0))
    else $error("nonzero grant on failed result");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
